// File: sv/wdmsm_pkg.sv
// Shared types, codes and helpers for the wet/dry mixer with soft mute and peak meters.
package wdmsm_pkg;

    // One stereo frame as it arrives on the input channel
    typedef struct packed {
        logic signed [15:0] dry_right;
        logic signed [15:0] dry_left;
        logic signed [15:0] wet_right;
        logic signed [15:0] wet_left;
        logic        [11:0] wet_gain;
        logic        [1:0]  mute_request;
        logic        [3:0]  level_clear_mask;
    } frame_t;

    // One result as it leaves on the output channel
    typedef struct packed {
        logic signed [15:0] out_right;
        logic signed [15:0] out_left;
        logic        [14:0] peak_in_right;
        logic        [14:0] peak_in_left;
        logic        [14:0] peak_out_right;
        logic        [14:0] peak_out_left;
        logic        [1:0]  mute_phase;
    } result_t;

    // Soft-mute phases
    typedef enum logic [1:0] {
        MODE_PLAY     = 2'd0,
        MODE_FADE_OUT = 2'd1,
        MODE_MUTED    = 2'd2,
        MODE_FADE_IN  = 2'd3
    } mute_mode_t;

    // Mute request codes
    localparam logic [1:0] REQ_MUTE   = 2'd1;
    localparam logic [1:0] REQ_UNMUTE = 2'd2;

    // Meter slots, also the bit order of the clear mask
    localparam int PK_IN_R  = 0;
    localparam int PK_IN_L  = 1;
    localparam int PK_OUT_R = 2;
    localparam int PK_OUT_L = 3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_WR,
        ST_MUL_DR,
        ST_MUL_WL,
        ST_MUL_DL,
        ST_MIX_L,
        ST_RAMP_MUL,
        ST_DIV_PREP,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_FINISH
    } seq_state_t;

    // Rectified magnitude; the most negative sample reads as full scale
    function automatic logic [14:0] mag15(input logic signed [15:0] s);
        logic [15:0] neg;
        begin
            neg = 16'(-s);
            if (!s[15])
            begin
                mag15 = s[14:0];
            end
            else if (s == 16'sh8000)
            begin
                mag15 = 15'h7fff;
            end
            else
            begin
                mag15 = neg[14:0];
            end
        end
    endfunction

endpackage

// File: sv/wet_dry_mix_soft_mute_meter.sv
// Top level: stereo wet/dry cross-fade, soft-mute ramp and peak meters on one shared multiplier.
//
//  channel  | handshake                  | item
//  ---------+----------------------------+------------------------------
//  frame    | frame_valid / frame_stall  | frame    (wdmsm_pkg::frame_t)
//  result   | result_valid / result_stall| result   (wdmsm_pkg::result_t)
//
// Sequence: while playing or muted an item passes through ST_MUL_WR, ST_MUL_DR, ST_MUL_WL,
// ST_MUL_DL, ST_MIX_L and ST_FINISH, then ST_IDLE before the next item is taken. During a fade
// the two ramp steps each add a multiply, a set-up state, a reciprocal multiply and a saturating
// write-back state. The single 16 x N multiplier and the staged division by the ramp length set
// this sequence; ST_FINISH also waits while a stalled result holds the output register.
// Reset: asynchronous, active low; mute phase starts at muted, ramp count and meters at zero.
// Stalls: frame_stall is high whenever the sequencer is busy; a finished result waits in the
// output register, and the next item is still taken while it waits.
module wet_dry_mix_soft_mute_meter #(
    parameter int RAMP_STEPS = 512,
    parameter int GAIN_BITS  = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    output logic               frame_stall,
    input  wdmsm_pkg::frame_t  frame,
    output logic               result_valid,
    input  logic               result_stall,
    output wdmsm_pkg::result_t result
);
    import wdmsm_pkg::*;

    // Width of the ramp count, which holds 0 .. RAMP_STEPS
    localparam int CW   = $clog2(RAMP_STEPS + 1);
    // Unsigned multiplier operand: gain share or ramp count
    localparam int BU   = (GAIN_BITS > CW) ? GAIN_BITS : CW;
    localparam int BW   = BU + 1;
    localparam int PW   = 16 + BW;
    localparam int AW   = PW + 1;
    // Divider numerator: quotient always fits 16 bits
    localparam int NW   = 16 + CW;
    localparam int GW   = (GAIN_BITS > 12) ? GAIN_BITS : 12;
    localparam int GMAX = (1 << GAIN_BITS) - 1;
    // Reciprocal of the ramp length, rounded up: exact floor for any numerator below 2^NW
    localparam int     LW      = $clog2(RAMP_STEPS);
    localparam int     SW      = NW + LW;
    localparam longint RECIP_L = ((longint'(1) << SW) + longint'(RAMP_STEPS) - 1)
                                 / longint'(RAMP_STEPS);

    localparam logic [GW-1:0]        GMAX_W  = GW'(GMAX);
    localparam logic [GAIN_BITS-1:0] GMAX_G  = GAIN_BITS'(GMAX);
    localparam logic [NW:0]          RECIP   = (NW + 1)'(RECIP_L);
    localparam logic [CW-1:0]        RAMP_C  = CW'(RAMP_STEPS);
    localparam logic [NW-1:0]        ROUND_N = NW'(RAMP_STEPS - 1);
    localparam logic signed [AW-1:0] MAX_A   = AW'(32767);
    localparam logic signed [AW-1:0] MIN_A   = AW'(-32768);

    // Arithmetic shift (floor) then clamp to 16 bits
    function automatic logic signed [15:0] sat_mix(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] sh;
        begin
            sh = acc >>> GAIN_BITS;
            if (sh > MAX_A)
            begin
                sat_mix = 16'sh7fff;
            end
            else if (sh < MIN_A)
            begin
                sat_mix = 16'sh8000;
            end
            else
            begin
                sat_mix = sh[15:0];
            end
        end
    endfunction

    // Sequencer and datapath registers
    seq_state_t              state_reg, state_next;
    frame_t                  frame_reg, frame_next;
    logic [GAIN_BITS-1:0]    g_reg, g_next;
    logic signed [AW-1:0]    acc_reg, acc_next;
    logic signed [15:0]      mix_r_reg, mix_r_next;
    logic signed [15:0]      mix_l_reg, mix_l_next;
    logic                    chan_reg, chan_next;
    logic                    neg_reg, neg_next;
    logic [NW-1:0]           num_reg, num_next;
    logic [15:0]             quo_reg, quo_next;
    mute_mode_t              mode_reg, mode_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [14:0]             peak_reg [4];
    logic [14:0]             peak_next [4];
    result_t                 result_reg, result_next;
    logic                    res_valid_reg, res_valid_next;

    // Shared multiplier
    logic signed [15:0]      mul_a;
    logic [BU-1:0]           mul_bu;
    logic signed [BW-1:0]    mul_b;
    logic signed [PW-1:0]    prod;

    // Work signals
    logic [GAIN_BITS-1:0]    gd;
    logic [GW-1:0]           g_w;
    logic                    take;
    logic [AW-1:0]           mag_acc;
    logic [NW-1:0]           num;
    logic [2*NW:0]           rprod;
    logic signed [16:0]      q17;
    logic signed [16:0]      ramp_val;
    logic signed [15:0]      ramp_sat;
    logic signed [15:0]      o_r, o_l;
    logic [14:0]             pk_or, pk_ol;
    logic [14:0]             m_r, m_l;
    logic [CW-1:0]           cnt_dec, cnt_inc;

    assign frame_stall  = (state_reg != ST_IDLE);
    assign take         = frame_valid && !frame_stall;
    assign result_valid = res_valid_reg;
    assign result       = result_reg;

    assign gd    = GMAX_G - g_reg;
    assign mul_b = $signed({1'b0, mul_bu});
    assign prod  = mul_a * mul_b;

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_a  = frame_reg.wet_right;
        mul_bu = BU'(g_reg);
        case (state_reg)
            ST_MUL_WR:
            begin
                mul_a  = frame_reg.wet_right;
                mul_bu = BU'(g_reg);
            end
            ST_MUL_DR:
            begin
                mul_a  = frame_reg.dry_right;
                mul_bu = BU'(gd);
            end
            ST_MUL_WL:
            begin
                mul_a  = frame_reg.wet_left;
                mul_bu = BU'(g_reg);
            end
            ST_MUL_DL:
            begin
                mul_a  = frame_reg.dry_left;
                mul_bu = BU'(gd);
            end
            ST_RAMP_MUL:
            begin
                mul_a  = chan_reg ? mix_l_reg : mix_r_reg;
                mul_bu = BU'(count_reg);
            end
            default:
            begin
                mul_a  = frame_reg.wet_right;
                mul_bu = BU'(g_reg);
            end
        endcase
    end

    // Divider helpers
    assign mag_acc  = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
    assign num      = NW'(mag_acc) + (acc_reg[AW-1] ? ROUND_N : '0);
    assign rprod    = num_reg * RECIP;
    assign q17      = $signed({1'b0, quo_reg});
    assign ramp_val = neg_reg ? -q17 : q17;
    assign ramp_sat = (ramp_val > 17'sd32767) ? 16'sh7fff :
                      (ramp_val < -17'sd32768) ? 16'sh8000 : ramp_val[15:0];

    // Finishing values
    assign o_r     = (mode_reg == MODE_MUTED) ? 16'sd0 : mix_r_reg;
    assign o_l     = (mode_reg == MODE_MUTED) ? 16'sd0 : mix_l_reg;
    assign m_r     = mag15(o_r);
    assign m_l     = mag15(o_l);
    assign pk_or   = (peak_reg[PK_OUT_R] < m_r) ? m_r : peak_reg[PK_OUT_R];
    assign pk_ol   = (peak_reg[PK_OUT_L] < m_l) ? m_l : peak_reg[PK_OUT_L];
    assign cnt_dec = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
    assign cnt_inc = count_reg + 1'b1;
    assign g_w     = GW'(frame.wet_gain);

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        frame_next     = frame_reg;
        g_next         = g_reg;
        acc_next       = acc_reg;
        mix_r_next     = mix_r_reg;
        mix_l_next     = mix_l_reg;
        chan_next      = chan_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        peak_next      = peak_reg;
        result_next    = result_reg;
        res_valid_next = res_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    frame_next = frame;
                    // Clamp the gain to the top of its range
                    g_next = (g_w > GMAX_W) ? GMAX_G : g_w[GAIN_BITS-1:0];
                    // Take a request only in a settled phase
                    if (mode_reg == MODE_PLAY && frame.mute_request == REQ_MUTE)
                    begin
                        mode_next  = MODE_FADE_OUT;
                        count_next = RAMP_C;
                    end
                    else if (mode_reg == MODE_MUTED && frame.mute_request == REQ_UNMUTE)
                    begin
                        mode_next  = MODE_FADE_IN;
                        count_next = '0;
                    end
                    // Input meters follow the dry samples
                    if (peak_reg[PK_IN_R] < mag15(frame.dry_right))
                    begin
                        peak_next[PK_IN_R] = mag15(frame.dry_right);
                    end
                    if (peak_reg[PK_IN_L] < mag15(frame.dry_left))
                    begin
                        peak_next[PK_IN_L] = mag15(frame.dry_left);
                    end
                    state_next = ST_MUL_WR;
                end
            end
            ST_MUL_WR:
            begin
                acc_next   = AW'(prod);
                state_next = ST_MUL_DR;
            end
            ST_MUL_DR:
            begin
                acc_next   = acc_reg + AW'(prod);
                state_next = ST_MUL_WL;
            end
            ST_MUL_WL:
            begin
                mix_r_next = sat_mix(acc_reg);
                acc_next   = AW'(prod);
                state_next = ST_MUL_DL;
            end
            ST_MUL_DL:
            begin
                acc_next   = acc_reg + AW'(prod);
                state_next = ST_MIX_L;
            end
            ST_MIX_L:
            begin
                mix_l_next = sat_mix(acc_reg);
                chan_next  = 1'b0;
                if (mode_reg == MODE_FADE_OUT || mode_reg == MODE_FADE_IN)
                begin
                    state_next = ST_RAMP_MUL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RAMP_MUL:
            begin
                acc_next   = AW'(prod);
                state_next = ST_DIV_PREP;
            end
            ST_DIV_PREP:
            begin
                // Floor division of a negative product: divide |v| + D - 1, then negate
                neg_next   = acc_reg[AW-1];
                num_next   = num;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                // Multiply by the reciprocal and keep the integer part
                quo_next   = rprod[SW+15:SW];
                state_next = ST_DIV_END;
            end
            ST_DIV_END:
            begin
                if (chan_reg)
                begin
                    mix_l_next = ramp_sat;
                    state_next = ST_FINISH;
                end
                else
                begin
                    mix_r_next = ramp_sat;
                    chan_next  = 1'b1;
                    state_next = ST_RAMP_MUL;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!res_valid_reg || !result_stall)
                begin
                    case (mode_reg)
                        MODE_FADE_OUT:
                        begin
                            count_next = cnt_dec;
                            if (cnt_dec == '0)
                            begin
                                mode_next = MODE_MUTED;
                            end
                        end
                        MODE_FADE_IN:
                        begin
                            if (cnt_inc >= RAMP_C)
                            begin
                                mode_next  = MODE_PLAY;
                                count_next = '0;
                            end
                            else
                            begin
                                count_next = cnt_inc;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    result_next.out_right      = o_r;
                    result_next.out_left       = o_l;
                    result_next.peak_in_right  = peak_reg[PK_IN_R];
                    result_next.peak_in_left   = peak_reg[PK_IN_L];
                    result_next.peak_out_right = pk_or;
                    result_next.peak_out_left  = pk_ol;
                    result_next.mute_phase     = mode_next;
                    res_valid_next             = 1'b1;
                    // Report, then drop the meters named in the mask
                    peak_next[PK_IN_R]  = frame_reg.level_clear_mask[PK_IN_R]  ? '0
                                          : peak_reg[PK_IN_R];
                    peak_next[PK_IN_L]  = frame_reg.level_clear_mask[PK_IN_L]  ? '0
                                          : peak_reg[PK_IN_L];
                    peak_next[PK_OUT_R] = frame_reg.level_clear_mask[PK_OUT_R] ? '0 : pk_or;
                    peak_next[PK_OUT_L] = frame_reg.level_clear_mask[PK_OUT_L] ? '0 : pk_ol;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_MUTED;
            count_reg     <= '0;
            peak_reg      <= '{default: '0};
            res_valid_reg <= 1'b0;
            chan_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            res_valid_reg <= res_valid_next;
            chan_reg      <= chan_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        g_reg      <= g_next;
        acc_reg    <= acc_next;
        mix_r_reg  <= mix_r_next;
        mix_l_reg  <= mix_l_next;
        neg_reg    <= neg_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        result_reg <= result_next;
    end

endmodule

// File: sv/wdmsm_checker.sv
// Port-level checks for the wet/dry mixer, bound to its top level.
module wdmsm_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               frame_valid,
    input logic               frame_stall,
    input wdmsm_pkg::frame_t  frame,
    input logic               result_valid,
    input logic               result_stall,
    input wdmsm_pkg::result_t result
);
    import wdmsm_pkg::*;

    // A taken item keeps the block busy, so it is not freed too soon after the take
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame_stall) |=> frame_stall ##1 frame_stall)
        else $error("block free too soon after taking an item");

    // A new result only comes out of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(frame_stall))
        else $error("result appeared without work");

    // When the block frees itself, its result is on show
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(frame_stall) |-> result_valid)
        else $error("block freed without a result");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

bind wet_dry_mix_soft_mute_meter wdmsm_port_checker u_wdmsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
